@@ hdl/running_sample_statistics_top_assert.svh @@
`ifndef RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH
`define RUNNING_SAMPLE_STATISTICS_TOP_ASSERT_SVH

// same-cycle implication
`define RSS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rss_pkg.sv @@
`timescale 1ns / 1ps

package rss_pkg;

    localparam int COUNT_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_COUNT_W     = 20;
    localparam int Q_W             = 32;
    localparam int WORD_W          = 64;
    localparam int DIV_W           = 128;
    localparam int ITER_W          = 8;
    localparam int SQ_W            = 45;
    localparam int SQRT_STEPS      = 32;
    localparam int RECIP_STEPS     = 33;
    localparam int MSQ_STEPS       = 84;

    localparam logic [1:0] REG_INIT_COUNT = 2'd0;
    localparam logic [1:0] REG_INIT_MEAN  = 2'd1;
    localparam logic [1:0] REG_INIT_HARM  = 2'd2;
    localparam logic [1:0] REG_INIT_DEV   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED_MM,
        ST_SEED_DD,
        ST_SEED_CM,
        ST_SEED_CSL,
        ST_SEED_CSH,
        ST_SEED_CSF,
        ST_SEED_DIV,
        ST_UPD_MUL,
        ST_UPD_SQ,
        ST_UPD_DIV,
        ST_MEAN,
        ST_MEAN_W,
        ST_HM,
        ST_HM_W,
        ST_M2,
        ST_MSQ,
        ST_MSQ_W,
        ST_SD,
        ST_SD_W,
        ST_QM,
        ST_QM_W,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [ITER_W-1:0] iters;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic over;
    } unit_rsp_t;

    function automatic logic [Q_W-1:0] sat_q32(logic [WORD_W-1:0] q, logic over);
        return (over || (|q[WORD_W-1:Q_W])) ? '1 : q[Q_W-1:0];
    endfunction

endpackage

@@ hdl/running_sample_statistics_top.sv @@
`timescale 1ns / 1ps

// Running count, arithmetic mean, harmonic mean, standard deviation and RMS of unsigned
// samples; the four statistics are in unsigned Q16.16 and the count is an integer. A zero
// sample skips the sum and reciprocal update steps. The work is done mostly by one shared
// shift-subtract unit that, while it runs, produces one quotient or root bit per cycle for
// the reciprocal, three divisions and two square roots, plus multiplier steps. A
// configuration write reloads every sum from the seed registers; during the reload no
// sample is accepted. A zero sample is flagged with zero_error and leaves the running
// sums untouched.

`include "running_sample_statistics_top_assert.svh"

module running_sample_statistics_top #(
    parameter int COUNT_BITS  = rss_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_BITS-1:0]            s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rss_pkg::CFG_COUNT_W-1:0]   m_sample_count,
    output logic [31:0]                       m_arith_mean,
    output logic [31:0]                       m_harm_mean,
    output logic [31:0]                       m_std_dev,
    output logic [31:0]                       m_quad_mean,
    output logic                              m_zero_error
);

    localparam int SUM_BITS = COUNT_BITS + 32;
    localparam int W        = rss_pkg::WORD_W;
    localparam int D        = rss_pkg::DIV_W;
    localparam int SQ_W     = rss_pkg::SQ_W;
    localparam logic [W-1:0] SUM_MAX = W'((65'd1 << SUM_BITS) - 65'd1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    rss_pkg::state_t state_reg, state_next;

    logic [rss_pkg::CFG_COUNT_W-1:0] cfg_count_reg, cfg_count_next;
    logic [31:0] cfg_mean_reg, cfg_mean_next;
    logic [31:0] cfg_harm_reg, cfg_harm_next;
    logic [31:0] cfg_dev_reg, cfg_dev_next;

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [SUM_BITS-1:0]   recip_reg, recip_next;
    logic [W-1:0]          sqsum_reg, sqsum_next;

    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                   err_reg, err_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [W-1:0]           acc_reg, acc_next;
    logic [31:0]            mean_reg, mean_next;
    logic [31:0]            hm_reg, hm_next;
    logic [W-1:0]           m2_reg, m2_next;
    logic [W-1:0]           msq_reg, msq_next;
    logic [31:0]            sd_reg, sd_next;
    logic [31:0]            qm_reg, qm_next;

    logic        m_valid_reg, m_valid_next;
    logic [rss_pkg::CFG_COUNT_W-1:0] o_count_reg, o_count_next;
    logic [31:0] o_mean_reg, o_mean_next;
    logic [31:0] o_hm_reg, o_hm_next;
    logic [31:0] o_sd_reg, o_sd_next;
    logic [31:0] o_qm_reg, o_qm_next;
    logic        o_err_reg, o_err_next;

    logic [31:0]           mul_a, mul_b;
    logic [W-1:0]          mul_p;
    rss_pkg::unit_req_t    ureq;
    rss_pkg::unit_rsp_t    ursp;
    logic [D-1:0]          unum;
    logic [W-1:0]          uden;
    logic [W-1:0]          uquo;

    logic [COUNT_BITS-1:0] seed_c;
    logic [79:0]           seed_tot;
    logic [64:0]           sq_add;
    logic [SUM_BITS:0]     sum_add;
    logic [SUM_BITS:0]     recip_add;
    logic                  unit_wait;

    assign seed_c    = COUNT_BITS'(cfg_count_reg);
    assign seed_tot  = 80'(acc_reg) + (80'(mul_p) << 32);
    assign sq_add    = 65'(sqsum_reg) + 65'(mul_p << 12);
    assign sum_add   = (SUM_BITS+1)'(sum_reg) + ((SUM_BITS+1)'(s_sample) << 16);
    assign recip_add = (SUM_BITS+1)'(recip_reg) + (SUM_BITS+1)'(uquo);

    rss_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    rss_shift_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .num     (unum),
        .den     (uden),
        .rsp     (ursp),
        .quo     (uquo)
    );

    assign cfg_ready = (state_reg == rss_pkg::ST_IDLE);
    assign s_ready   = (state_reg == rss_pkg::ST_IDLE) && !cfg_valid;

    always_comb begin
        state_next     = state_reg;
        cfg_count_next = cfg_count_reg;
        cfg_mean_next  = cfg_mean_reg;
        cfg_harm_next  = cfg_harm_reg;
        cfg_dev_next   = cfg_dev_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        recip_next     = recip_reg;
        sqsum_next     = sqsum_reg;
        x_next         = x_reg;
        err_next       = err_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        mean_next      = mean_reg;
        hm_next        = hm_reg;
        m2_next        = m2_reg;
        msq_next       = msq_reg;
        sd_next        = sd_reg;
        qm_next        = qm_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        o_count_next   = o_count_reg;
        o_mean_next    = o_mean_reg;
        o_hm_next      = o_hm_reg;
        o_sd_next      = o_sd_reg;
        o_qm_next      = o_qm_reg;
        o_err_next     = o_err_reg;
        mul_a          = '0;
        mul_b          = '0;
        ureq           = '0;
        unum           = '0;
        uden           = '0;

        unique case (state_reg)
            rss_pkg::ST_IDLE: begin
                if (cfg_valid) begin
                    unique case (cfg_index)
                        rss_pkg::REG_INIT_COUNT: cfg_count_next = cfg_data[rss_pkg::CFG_COUNT_W-1:0];
                        rss_pkg::REG_INIT_MEAN:  cfg_mean_next  = cfg_data;
                        rss_pkg::REG_INIT_HARM:  cfg_harm_next  = cfg_data;
                        rss_pkg::REG_INIT_DEV:   cfg_dev_next   = cfg_data;
                        default:                 cfg_dev_next   = cfg_dev_reg;
                    endcase
                    state_next = rss_pkg::ST_SEED_MM;
                end else if (s_valid) begin
                    x_next   = s_sample;
                    err_next = (s_sample == '0);
                    if (s_sample != '0) begin
                        if (cnt_reg != CNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        sum_next = (sum_add > (SUM_BITS+1)'(SUM_MAX)) ?
                                   SUM_BITS'(SUM_MAX) : sum_add[SUM_BITS-1:0];
                        state_next = rss_pkg::ST_UPD_MUL;
                    end else begin
                        state_next = rss_pkg::ST_MEAN;
                    end
                end
            end
            rss_pkg::ST_SEED_MM: begin
                mul_a      = cfg_mean_reg;
                mul_b      = cfg_mean_reg;
                state_next = rss_pkg::ST_SEED_DD;
            end
            rss_pkg::ST_SEED_DD: begin
                mul_a      = cfg_dev_reg;
                mul_b      = cfg_dev_reg;
                sq_next    = SQ_W'(mul_p >> 20);
                state_next = rss_pkg::ST_SEED_CM;
            end
            rss_pkg::ST_SEED_CM: begin
                mul_a      = 32'(seed_c);
                mul_b      = cfg_mean_reg;
                sq_next    = sq_reg + SQ_W'(mul_p >> 20);
                state_next = rss_pkg::ST_SEED_CSL;
            end
            rss_pkg::ST_SEED_CSL: begin
                mul_a      = 32'(seed_c);
                mul_b      = sq_reg[31:0];
                cnt_next   = seed_c;
                sum_next   = (mul_p > SUM_MAX) ? SUM_BITS'(SUM_MAX) : SUM_BITS'(mul_p);
                state_next = rss_pkg::ST_SEED_CSH;
            end
            rss_pkg::ST_SEED_CSH: begin
                mul_a      = 32'(seed_c);
                mul_b      = 32'(sq_reg[SQ_W-1:32]);
                acc_next   = mul_p;
                state_next = rss_pkg::ST_SEED_CSF;
            end
            rss_pkg::ST_SEED_CSF: begin
                sqsum_next = (|seed_tot[79:64]) ? '1 : seed_tot[63:0];
                if (seed_c == '0) begin
                    recip_next = '0;
                    state_next = rss_pkg::ST_IDLE;
                end else begin
                    ureq.start = 1'b1;
                    ureq.iters = rss_pkg::ITER_W'(COUNT_BITS + 48);
                    unum       = {seed_c, {(D-COUNT_BITS){1'b0}}};
                    uden       = W'(cfg_harm_reg);
                    state_next = rss_pkg::ST_SEED_DIV;
                end
            end
            rss_pkg::ST_SEED_DIV: begin
                if (ursp.done) begin
                    recip_next = (ursp.over || (uquo > SUM_MAX)) ?
                                 SUM_BITS'(SUM_MAX) : SUM_BITS'(uquo);
                    state_next = rss_pkg::ST_IDLE;
                end
            end
            rss_pkg::ST_UPD_MUL: begin
                mul_a      = 32'(x_reg);
                mul_b      = 32'(x_reg);
                ureq.start = 1'b1;
                ureq.iters = rss_pkg::ITER_W'(rss_pkg::RECIP_STEPS);
                unum       = {1'b1, {(D-1){1'b0}}};
                uden       = W'(x_reg);
                state_next = rss_pkg::ST_UPD_SQ;
            end
            rss_pkg::ST_UPD_SQ: begin
                sqsum_next = sq_add[64] ? '1 : sq_add[63:0];
                state_next = rss_pkg::ST_UPD_DIV;
            end
            rss_pkg::ST_UPD_DIV: begin
                if (ursp.done) begin
                    recip_next = (recip_add > (SUM_BITS+1)'(SUM_MAX)) ?
                                 SUM_BITS'(SUM_MAX) : recip_add[SUM_BITS-1:0];
                    state_next = rss_pkg::ST_MEAN;
                end
            end
            rss_pkg::ST_MEAN: begin
                if (cnt_reg == '0) begin
                    mean_next  = '0;
                    hm_next    = '0;
                    sd_next    = '0;
                    qm_next    = '0;
                    state_next = rss_pkg::ST_OUT;
                end else begin
                    ureq.start = 1'b1;
                    ureq.iters = rss_pkg::ITER_W'(SUM_BITS);
                    unum       = {sum_reg, {(D-SUM_BITS){1'b0}}};
                    uden       = W'(cnt_reg);
                    state_next = rss_pkg::ST_MEAN_W;
                end
            end
            rss_pkg::ST_MEAN_W: begin
                if (ursp.done) begin
                    mean_next  = rss_pkg::sat_q32(uquo, ursp.over);
                    state_next = rss_pkg::ST_HM;
                end
            end
            rss_pkg::ST_HM: begin
                ureq.start = 1'b1;
                ureq.iters = rss_pkg::ITER_W'(COUNT_BITS + 48);
                unum       = {cnt_reg, {(D-COUNT_BITS){1'b0}}};
                uden       = W'(recip_reg);
                state_next = rss_pkg::ST_HM_W;
            end
            rss_pkg::ST_HM_W: begin
                if (ursp.done) begin
                    hm_next    = rss_pkg::sat_q32(uquo, ursp.over);
                    state_next = rss_pkg::ST_M2;
                end
            end
            rss_pkg::ST_M2: begin
                mul_a      = mean_reg;
                mul_b      = mean_reg;
                state_next = rss_pkg::ST_MSQ;
            end
            rss_pkg::ST_MSQ: begin
                m2_next    = mul_p;
                ureq.start = 1'b1;
                ureq.iters = rss_pkg::ITER_W'(rss_pkg::MSQ_STEPS);
                unum       = {sqsum_reg, {(D-W){1'b0}}};
                uden       = W'(cnt_reg);
                state_next = rss_pkg::ST_MSQ_W;
            end
            rss_pkg::ST_MSQ_W: begin
                if (ursp.done) begin
                    msq_next   = ursp.over ? '1 : uquo;
                    state_next = rss_pkg::ST_SD;
                end
            end
            rss_pkg::ST_SD: begin
                ureq.start     = 1'b1;
                ureq.sqrt_mode = 1'b1;
                ureq.iters     = rss_pkg::ITER_W'(rss_pkg::SQRT_STEPS);
                uden           = (msq_reg > m2_reg) ? (msq_reg - m2_reg) : '0;
                state_next     = rss_pkg::ST_SD_W;
            end
            rss_pkg::ST_SD_W: begin
                if (ursp.done) begin
                    sd_next    = uquo[31:0];
                    state_next = rss_pkg::ST_QM;
                end
            end
            rss_pkg::ST_QM: begin
                ureq.start     = 1'b1;
                ureq.sqrt_mode = 1'b1;
                ureq.iters     = rss_pkg::ITER_W'(rss_pkg::SQRT_STEPS);
                uden           = msq_reg;
                state_next     = rss_pkg::ST_QM_W;
            end
            rss_pkg::ST_QM_W: begin
                if (ursp.done) begin
                    qm_next    = uquo[31:0];
                    state_next = rss_pkg::ST_OUT;
                end
            end
            rss_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_count_next = rss_pkg::CFG_COUNT_W'(cnt_reg);
                    o_mean_next  = mean_reg;
                    o_hm_next    = hm_reg;
                    o_sd_next    = sd_reg;
                    o_qm_next    = qm_reg;
                    o_err_next   = err_reg;
                    state_next   = rss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rss_pkg::ST_IDLE;
            cfg_count_reg <= '0;
            cfg_mean_reg  <= '0;
            cfg_harm_reg  <= '0;
            cfg_dev_reg   <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            recip_reg     <= '0;
            sqsum_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_count_reg <= cfg_count_next;
            cfg_mean_reg  <= cfg_mean_next;
            cfg_harm_reg  <= cfg_harm_next;
            cfg_dev_reg   <= cfg_dev_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            recip_reg     <= recip_next;
            sqsum_reg     <= sqsum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        err_reg     <= err_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        mean_reg    <= mean_next;
        hm_reg      <= hm_next;
        m2_reg      <= m2_next;
        msq_reg     <= msq_next;
        sd_reg      <= sd_next;
        qm_reg      <= qm_next;
        o_count_reg <= o_count_next;
        o_mean_reg  <= o_mean_next;
        o_hm_reg    <= o_hm_next;
        o_sd_reg    <= o_sd_next;
        o_qm_reg    <= o_qm_next;
        o_err_reg   <= o_err_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_count = o_count_reg;
    assign m_arith_mean   = o_mean_reg;
    assign m_harm_mean    = o_hm_reg;
    assign m_std_dev      = o_sd_reg;
    assign m_quad_mean    = o_qm_reg;
    assign m_zero_error   = o_err_reg;

    assign unit_wait = state_reg inside {rss_pkg::ST_SEED_DIV, rss_pkg::ST_UPD_DIV,
                                         rss_pkg::ST_MEAN_W, rss_pkg::ST_HM_W,
                                         rss_pkg::ST_MSQ_W, rss_pkg::ST_SD_W,
                                         rss_pkg::ST_QM_W};

    `RSS_ASSERT_NXT(a_cfg_reseeds, cfg_valid && cfg_ready,
        state_reg == rss_pkg::ST_SEED_MM, "config beat did not start reseed")
    `RSS_ASSERT_NXT(a_zero_keeps_count, s_valid && s_ready && (s_sample == '0),
        err_reg && (cnt_reg == $past(cnt_reg)), "zero sample changed count or lost flag")
    `RSS_ASSERT_IMP(a_done_in_wait, ursp.done, unit_wait, "unit finished outside a wait state")
    `RSS_ASSERT_NXT(a_out_holds, (state_reg == rss_pkg::ST_OUT) && m_valid_reg && !m_ready,
        state_reg == rss_pkg::ST_OUT, "result overwrote a pending beat")

endmodule

@@ hdl/rss_mul.sv @@
`timescale 1ns / 1ps

module rss_mul (
    input  logic                          aclk,
    input  logic [rss_pkg::Q_W-1:0]       a,
    input  logic [rss_pkg::Q_W-1:0]       b,
    output logic [rss_pkg::WORD_W-1:0]    p
);

    logic [rss_pkg::WORD_W-1:0] p_reg;
    logic [rss_pkg::WORD_W-1:0] p_next;

    assign p_next = rss_pkg::WORD_W'(a) * rss_pkg::WORD_W'(b);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

@@ hdl/rss_shift_unit.sv @@
`timescale 1ns / 1ps

module rss_shift_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rss_pkg::unit_req_t                req,
    input  logic [rss_pkg::DIV_W-1:0]         num,
    input  logic [rss_pkg::WORD_W-1:0]        den,
    output rss_pkg::unit_rsp_t                rsp,
    output logic [rss_pkg::WORD_W-1:0]        quo
);

    localparam int W = rss_pkg::WORD_W;
    localparam int D = rss_pkg::DIV_W;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          mode_reg, mode_next;
    logic [rss_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [D-1:0]                  num_reg, num_next;
    logic [D-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  den_reg, den_next;
    logic [W-1:0]                  bit_reg, bit_next;

    logic [W:0]   rem_sh;
    logic         div_ge;
    logic [W:0]   div_res;
    logic [W-1:0] sq_try;
    logic         sq_ge;

    assign rem_sh  = {rem_reg, num_reg[D-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign div_res = div_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign sq_try  = quo_reg[W-1:0] + bit_reg;
    assign sq_ge   = rem_reg >= sq_try;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        iter_next = iter_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bit_next  = bit_reg;
        if (req.start) begin
            busy_next = 1'b1;
            mode_next = req.sqrt_mode;
            iter_next = req.iters;
            num_next  = num;
            quo_next  = '0;
            den_next  = den;
            rem_next  = req.sqrt_mode ? den : '0;
            bit_next  = W'(1) << (W - 2);
        end else if (busy_reg) begin
            iter_next = iter_reg - 1'b1;
            if (iter_reg == rss_pkg::ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (mode_reg) begin
                bit_next = bit_reg >> 2;
                if (sq_ge) begin
                    rem_next = rem_reg - sq_try;
                    quo_next = D'((quo_reg[W-1:0] >> 1) + bit_reg);
                end else begin
                    quo_next = D'(quo_reg[W-1:0] >> 1);
                end
            end else begin
                num_next = num_reg << 1;
                rem_next = div_res[W-1:0];
                quo_next = {quo_reg[D-2:0], div_ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bit_reg  <= bit_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.over = |quo_reg[D-1:W];
    assign quo      = quo_reg[W-1:0];

endmodule
